/* design/assert_macros.svh */
// Assertion macros shared by the RTL of the box suppression block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define GBS_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define GBS_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another in the next cycle.
`define GBS_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/gbs_pkg.sv */
// Shared constants and types of the greedy box suppression block.
package gbs_pkg;

	// Default sizes.
	localparam int unsigned MAX_KEPT_DEF   = 64;
	localparam int unsigned COORD_BITS_DEF = 12;

	// Fixed field widths.
	localparam int unsigned TAG_W        = 4;
	localparam int unsigned PCT_W        = 7;
	localparam int unsigned KEPT_TOTAL_W = 7;
	localparam int unsigned CFG_IDX_W    = 1;
	localparam int unsigned CFG_DATA_W   = 7;

	// Thresholds are percentages, so ratios are compared against inter * 100.
	localparam int unsigned PCT_SCALE = 100;

	// Threshold values after reset.
	localparam logic [PCT_W-1:0] IOU_THR_RST = 7'd30;
	localparam logic [PCT_W-1:0] IOM_THR_RST = 7'd60;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IOU_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IOM_THR = 1'b1;

	// Suppression flag that travels along the chain of cells.
	typedef struct packed {
		logic vld;
		logic supp;
	} flag_t;

endpackage

/* design/gbs_cell.sv */
// One cell of the chain: holds a kept box and compares each passing candidate with it.
module gbs_cell #(
	parameter int unsigned COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic [gbs_pkg::PCT_W-1:0]                    iou_thr,
	input  logic [gbs_pkg::PCT_W-1:0]                    iom_thr,
	input  logic                                         occupied,
	input  logic                                         store_en,
	input  logic [4*COORD_BITS+gbs_pkg::TAG_W-1:0]       wr_box,
	input  logic [2*COORD_BITS-1:0]                      wr_area,
	input  logic [4*COORD_BITS+gbs_pkg::TAG_W-1:0]       prev_box,
	input  logic [2*COORD_BITS-1:0]                      prev_area,
	input  gbs_pkg::flag_t                               prev_flag,
	output logic [4*COORD_BITS+gbs_pkg::TAG_W-1:0]       next_box,
	output logic [2*COORD_BITS-1:0]                      next_area,
	output gbs_pkg::flag_t                               next_flag
);
	import gbs_pkg::*;

	localparam int unsigned BOX_W  = 4*COORD_BITS + TAG_W;
	localparam int unsigned AREA_W = 2*COORD_BITS;
	localparam int unsigned UNI_W  = AREA_W + 1;
	localparam int unsigned PROD_W = UNI_W + PCT_W;

	logic [BOX_W-1:0]      box_q;
	logic [AREA_W-1:0]     area_q;
	logic [BOX_W-1:0]      cand_box_q;
	logic [AREA_W-1:0]     cand_area_q;
	flag_t                 flag_q;

	logic [COORD_BITS-1:0] kx0, ky0, kx1, ky1;
	logic [COORD_BITS-1:0] nx0, ny0, nx1, ny1;
	logic [TAG_W-1:0]      ktag, ntag;
	logic [COORD_BITS-1:0] lx, rx, ty, by;
	logic [COORD_BITS-1:0] iw, ih;

	logic [AREA_W-1:0]     inter_s1;
	logic                  match_s1;

	logic [AREA_W-1:0]     amin;
	logic [UNI_W-1:0]      uni;

	logic [PROD_W-1:0]     lhs_s2;
	logic [PROD_W-1:0]     iom_prod_s2;
	logic [PROD_W-1:0]     iou_prod_s2;
	logic                  amin_nz_s2;
	logic                  uni_nz_s2;
	logic                  match_s2;
	logic                  hit;

	// Stored kept box; written when the block keeps a box for this slot.
	always_ff @(posedge clk) begin
		if (store_en) begin
			box_q  <= wr_box;
			area_q <= wr_area;
		end
	end

	// The candidate moves on to the neighbor every cycle.
	always_ff @(posedge clk) begin
		cand_box_q  <= prev_box;
		cand_area_q <= prev_area;
	end

	assign next_box  = cand_box_q;
	assign next_area = cand_area_q;

	// Unpack the stored box and the incoming candidate.
	assign kx0  = box_q[COORD_BITS-1:0];
	assign ky0  = box_q[2*COORD_BITS-1:COORD_BITS];
	assign kx1  = box_q[3*COORD_BITS-1:2*COORD_BITS];
	assign ky1  = box_q[4*COORD_BITS-1:3*COORD_BITS];
	assign ktag = box_q[BOX_W-1:4*COORD_BITS];
	assign nx0  = prev_box[COORD_BITS-1:0];
	assign ny0  = prev_box[2*COORD_BITS-1:COORD_BITS];
	assign nx1  = prev_box[3*COORD_BITS-1:2*COORD_BITS];
	assign ny1  = prev_box[4*COORD_BITS-1:3*COORD_BITS];
	assign ntag = prev_box[BOX_W-1:4*COORD_BITS];

	// First stage: overlap rectangle; inverted edges give a zero span.
	always_comb begin
		lx = (kx0 > nx0) ? kx0 : nx0;
		rx = (kx1 < nx1) ? kx1 : nx1;
		ty = (ky0 > ny0) ? ky0 : ny0;
		by = (ky1 < ny1) ? ky1 : ny1;
		iw = (rx > lx) ? (rx - lx) : '0;
		ih = (by > ty) ? (by - ty) : '0;
	end

	always_ff @(posedge clk) begin
		inter_s1 <= AREA_W'(iw) * AREA_W'(ih);
		match_s1 <= occupied && (ktag == ntag);
	end

	// Second stage: denominators and the threshold products.
	always_comb begin
		amin = (area_q < cand_area_q) ? area_q : cand_area_q;
		uni  = UNI_W'(area_q) + UNI_W'(cand_area_q) - UNI_W'(inter_s1);
	end

	always_ff @(posedge clk) begin
		lhs_s2      <= PROD_W'(inter_s1) * PROD_W'(PCT_SCALE);
		iom_prod_s2 <= PROD_W'(iom_thr) * PROD_W'(amin);
		iou_prod_s2 <= PROD_W'(iou_thr) * PROD_W'(uni);
		amin_nz_s2  <= (amin != '0);
		uni_nz_s2   <= (uni != '0);
		match_s2    <= match_s1;
	end

	// Third stage: a zero denominator never suppresses through its ratio.
	assign hit = match_s2 &&
		((amin_nz_s2 && (lhs_s2 >= iom_prod_s2)) ||
		 (uni_nz_s2 && (lhs_s2 >= iou_prod_s2)));

	// Fold this cell's verdict into the flag and hand it on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q.vld  <= 1'b0;
			flag_q.supp <= 1'b0;
		end else begin
			flag_q.vld  <= prev_flag.vld;
			flag_q.supp <= prev_flag.supp | (prev_flag.vld & hit);
		end
	end

	assign next_flag = flag_q;

endmodule

/* design/greedy_box_suppression_top.sv */
// Greedy box suppression: each accepted box beat walks a chain of MAX_KEPT cells,
// one cell per cycle, and every cell compares it with the kept box it holds (same
// scale tag, intersection over smaller area and over union, exact cross products).
// Only one box is in flight at a time: the next box is accepted once the result
// of the last one sits in the output register. A kept box goes into the first
// free cell; with all cells full it is reported as kept with store_overflow set
// and is not stored. first_in_list empties the store first.
`include "assert_macros.svh"

module greedy_box_suppression_top #(
	parameter int unsigned MAX_KEPT   = gbs_pkg::MAX_KEPT_DEF,
	parameter int unsigned COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [gbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gbs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [COORD_BITS-1:0]              x_left,
	input  logic [COORD_BITS-1:0]              y_top,
	input  logic [COORD_BITS-1:0]              x_right,
	input  logic [COORD_BITS-1:0]              y_bottom,
	input  logic [gbs_pkg::TAG_W-1:0]          scale_tag,
	input  logic                               first_in_list,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               kept,
	output logic                               store_overflow,
	output logic [gbs_pkg::KEPT_TOTAL_W-1:0]   kept_total
);
	import gbs_pkg::*;

	localparam int unsigned CNT_W  = $clog2(MAX_KEPT + 1);
	localparam int unsigned AREA_W = 2*COORD_BITS;
	localparam int unsigned BOX_W  = 4*COORD_BITS + TAG_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_AREA = 4'b0010,
		ST_WALK = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [PCT_W-1:0]        iou_thr_q;
	logic [PCT_W-1:0]        iom_thr_q;
	logic [BOX_W-1:0]        in_box_q;
	logic [AREA_W-1:0]       head_area_q;
	logic [2:0]              lead_q;
	logic [CNT_W-1:0]        count_q;
	logic                    res_kept_q;
	logic                    res_ovf_q;
	logic                    out_valid_q;
	logic                    kept_q;
	logic                    store_overflow_q;
	logic [KEPT_TOTAL_W-1:0] kept_total_q;

	logic                    in_acc;
	logic                    out_free;
	logic                    done;
	logic                    keep;
	logic                    full;
	logic                    store_en;
	logic [COORD_BITS-1:0]   hx0, hy0, hx1, hy1;
	logic [COORD_BITS-1:0]   hw, hh;

	logic [BOX_W-1:0]        box_link  [MAX_KEPT+1];
	logic [AREA_W-1:0]       area_link [MAX_KEPT+1];
	flag_t                   flag_link [MAX_KEPT+1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iou_thr_q <= IOU_THR_RST;
			iom_thr_q <= IOM_THR_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IOU_THR: iou_thr_q <= cfg_data;
				REG_IOM_THR: iom_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input handshake: one box in flight at a time.
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_box_q <= {scale_tag, y_bottom, x_right, y_top, x_left};
		end
	end

	// Candidate area, computed once before the walk.
	assign hx0 = in_box_q[COORD_BITS-1:0];
	assign hy0 = in_box_q[2*COORD_BITS-1:COORD_BITS];
	assign hx1 = in_box_q[3*COORD_BITS-1:2*COORD_BITS];
	assign hy1 = in_box_q[4*COORD_BITS-1:3*COORD_BITS];
	assign hw  = (hx1 > hx0) ? (hx1 - hx0) : '0;
	assign hh  = (hy1 > hy0) ? (hy1 - hy0) : '0;

	always_ff @(posedge clk) begin
		if (state_q == ST_AREA) begin
			head_area_q <= AREA_W'(hw) * AREA_W'(hh);
		end
	end

	// The flag enters the first cell when that cell reaches its last stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
		end else begin
			lead_q <= {lead_q[1:0], state_q == ST_AREA};
		end
	end

	assign box_link[0]       = in_box_q;
	assign area_link[0]      = head_area_q;
	assign flag_link[0].vld  = lead_q[2];
	assign flag_link[0].supp = 1'b0;

	// Chain of cells; cell i holds kept box i.
	for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
		gbs_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.iou_thr   (iou_thr_q),
			.iom_thr   (iom_thr_q),
			.occupied  (count_q > CNT_W'(i)),
			.store_en  (store_en && (count_q == CNT_W'(i))),
			.wr_box    (in_box_q),
			.wr_area   (head_area_q),
			.prev_box  (box_link[i]),
			.prev_area (area_link[i]),
			.prev_flag (flag_link[i]),
			.next_box  (box_link[i+1]),
			.next_area (area_link[i+1]),
			.next_flag (flag_link[i+1])
		);
	end

	// Verdict at the end of the chain.
	assign done     = flag_link[MAX_KEPT].vld;
	assign keep     = !flag_link[MAX_KEPT].supp;
	assign full     = (count_q == CNT_W'(MAX_KEPT));
	assign store_en = (state_q == ST_WALK) && done && keep && !full;

	// Fill count of the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_acc && first_in_list) begin
			count_q <= '0;
		end else if (store_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_WALK) && done) begin
			res_kept_q <= keep;
			res_ovf_q  <= keep && full;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_AREA;
				ST_AREA: state_q <= ST_WALK;
				ST_WALK: if (done) state_q <= ST_DONE;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register; holds the result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			kept_q           <= res_kept_q;
			store_overflow_q <= res_ovf_q;
			kept_total_q     <= KEPT_TOTAL_W'(count_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign kept           = kept_q;
	assign store_overflow = store_overflow_q;
	assign kept_total     = kept_total_q;

	// Checks on the store bookkeeping and the chain timing.
	`GBS_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_KEPT), "kept count above capacity")
	`GBS_IMPLY(a_done_in_walk, done, state_q == ST_WALK, "chain verdict outside the walk")
	`GBS_NEXT(a_store_count, store_en, count_q == $past(count_q) + CNT_W'(1), "store without count")
	`GBS_IMPLY(a_ovf_full, (state_q == ST_DONE) && res_ovf_q, full, "overflow with free cells")

endmodule
